// File: sv/mcbpt_pkg.sv
// Package for the multi-channel beep pattern timer.
// Holds the action codes, the per-lane command struct and the shared constants.
// No dependencies.
`timescale 1ns / 1ps

package mcbpt_pkg;

  localparam int DEF_NUM_CHANNELS = 4;
  localparam int OUT_LANES        = 4;
  localparam int CH_W             = 2;
  localparam int LEN_W            = 8;
  localparam int IN_DATA_W        = 32;
  localparam int OUT_DATA_W       = 8;

  localparam logic [LEN_W-1:0] CNT_PRESET    = 8'hFE;
  localparam logic [LEN_W-1:0] FOREVER_LIMIT = 8'd100;

  typedef enum logic {
    ACT_TICK = 1'b0,
    ACT_RING = 1'b1
  } action_t;

  typedef struct packed {
    logic             tick;
    logic             load;
    logic [LEN_W-1:0] repeat_count;
    logic [LEN_W-1:0] high_ticks;
    logic [LEN_W-1:0] low_ticks;
  } lane_cmd_t;

endpackage

// File: sv/mcbpt_lane.sv
// One buzzer channel: level, phase counter, edge count and phase lengths.
// Depends on mcbpt_pkg for the command struct and constants.
`timescale 1ns / 1ps

module mcbpt_lane (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  mcbpt_pkg::lane_cmd_t cmd,
  output logic                 level,
  output logic                 fin
);
  import mcbpt_pkg::*;

  logic             level_r, level_nxt;
  logic [LEN_W-1:0] cnt_r, cnt_nxt;
  logic [LEN_W-1:0] edges_r, edges_nxt;
  logic             forever_r, forever_nxt;
  logic [LEN_W-1:0] on_r, on_nxt;
  logic [LEN_W-1:0] off_r, off_nxt;

  logic             active;
  logic [LEN_W-1:0] cnt_inc;
  logic [LEN_W-1:0] len;
  logic             wrap;
  logic             ring_forever;

  assign active       = forever_r || (edges_r != '0);
  assign cnt_inc      = cnt_r + LEN_W'(1);
  assign len          = level_r ? on_r : off_r;
  assign wrap         = cnt_inc > len;
  assign ring_forever = cmd.repeat_count > FOREVER_LIMIT;

  always_comb begin
    level_nxt   = level_r;
    cnt_nxt     = cnt_r;
    edges_nxt   = edges_r;
    forever_nxt = forever_r;
    on_nxt      = on_r;
    off_nxt     = off_r;
    fin         = 1'b0;
    if (en && cmd.load) begin
      level_nxt   = 1'b0;
      cnt_nxt     = CNT_PRESET;
      forever_nxt = ring_forever;
      edges_nxt   = ring_forever ? '0 : {cmd.repeat_count[LEN_W-2:0], 1'b0};
      on_nxt      = cmd.high_ticks;
      off_nxt     = cmd.low_ticks;
    end else if (en && cmd.tick && active) begin
      cnt_nxt = cnt_inc;
      if (wrap) begin
        cnt_nxt   = '0;
        level_nxt = ~level_r;
        if (!forever_r) begin
          edges_nxt = edges_r - LEN_W'(1);
          fin       = (edges_r == LEN_W'(1));
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r   <= 1'b0;
      cnt_r     <= '0;
      edges_r   <= '0;
      forever_r <= 1'b0;
      on_r      <= '0;
      off_r     <= '0;
    end else begin
      level_r   <= level_nxt;
      cnt_r     <= cnt_nxt;
      edges_r   <= edges_nxt;
      forever_r <= forever_nxt;
      on_r      <= on_nxt;
      off_r     <= off_nxt;
    end
  end

  assign level = level_nxt;

endmodule

// File: sv/multi_channel_beep_pattern_timer_core.sv
// Top level of the multi-channel beep pattern timer.
// Depends on mcbpt_pkg and instantiates one mcbpt_lane per channel.
`timescale 1ns / 1ps

// Takes one word per cycle while results are taken, either a tick for all
// channels or a ring command for one channel, and returns one result word for
// each. A word is held in the input register, then every channel lane updates
// in parallel and the levels and finish bits land in the result register. A
// stalled result holds the input register, which then holds the input side.

module multi_channel_beep_pattern_timer_core #(
  parameter int NUM_CHANNELS = mcbpt_pkg::DEF_NUM_CHANNELS
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // channel[1:0], repeat_count[9:2], high_ticks[17:10], low_ticks[25:18], zero
  input  logic [mcbpt_pkg::IN_DATA_W-1:0]  in_tdata,
  // action[0]
  input  logic                             in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // buzzer_levels[3:0], finished_mask[7:4]
  output logic [mcbpt_pkg::OUT_DATA_W-1:0] out_tdata
);
  import mcbpt_pkg::*;

  logic                 s_valid_r;
  logic                 s_action_r;
  logic [CH_W-1:0]      s_ch_r;
  logic [LEN_W-1:0]     s_rep_r, s_hi_r, s_lo_r;
  logic                 out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;
  logic                 advance;
  logic                 fire;

  logic [NUM_CHANNELS-1:0] lvl;
  logic [NUM_CHANNELS-1:0] fin;
  logic [OUT_LANES-1:0]    lvl4;
  logic [OUT_LANES-1:0]    fin4;

  assign advance   = !out_valid_r || out_tready;
  assign in_tready = !s_valid_r || advance;
  assign fire      = s_valid_r && advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_valid_r <= 1'b0;
    end else if (in_tready) begin
      s_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s_action_r <= in_tuser;
      s_ch_r     <= in_tdata[1:0];
      s_rep_r    <= in_tdata[9:2];
      s_hi_r     <= in_tdata[17:10];
      s_lo_r     <= in_tdata[25:18];
    end
  end

  for (genvar c = 0; c < NUM_CHANNELS; c++) begin : g_lane
    lane_cmd_t cmd;
    assign cmd.tick         = (s_action_r == ACT_TICK);
    assign cmd.load         = (s_action_r == ACT_RING) && (int'(s_ch_r) == c);
    assign cmd.repeat_count = s_rep_r;
    assign cmd.high_ticks   = s_hi_r;
    assign cmd.low_ticks    = s_lo_r;

    mcbpt_lane u_lane (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (fire),
      .cmd   (cmd),
      .level (lvl[c]),
      .fin   (fin[c])
    );
  end

  for (genvar i = 0; i < OUT_LANES; i++) begin : g_out
    if (i < NUM_CHANNELS) begin : g_on
      assign lvl4[i] = lvl[i];
      assign fin4[i] = fin[i];
    end else begin : g_off
      assign lvl4[i] = 1'b0;
      assign fin4[i] = 1'b0;
    end
  end

  assign out_data_nxt = {fin4, lvl4};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
